// ===== hdl/lbp_pkg.sv =====
// Shared constants, payload types and helper functions for the LBP histogram block.
package lbp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COUNT_BITS = 20;

    localparam int CFG_W   = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int BIN_W   = 8;
    localparam int NBINS   = 1 << BIN_W;
    localparam int FRAC_W  = 17;
    localparam int FRAC_SH = 16;
    localparam int DVD_W   = COUNT_BITS + FRAC_SH;

    localparam logic [7:0]            BACKGROUND = 8'd255;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [FRAC_W-1:0]     FRAC_ONE   = FRAC_W'(1) << FRAC_SH;

    localparam logic [CFG_W-1:0] SIZE_MIN  = CFG_W'(3);
    localparam logic [CFG_W-1:0] WIDTH_MX  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_MX = CFG_W'(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [7:0]       pixel_value;
        logic [BIN_W-1:0] bin_index;
    } t_lbp_in;

    typedef struct packed {
        logic                  pattern_valid;
        logic [7:0]            pattern_code;
        logic [COUNT_BITS-1:0] bin_count;
        logic [FRAC_W-1:0]     bin_fraction;
        logic [COUNT_BITS-1:0] total_patterns;
    } t_lbp_out;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [COL_W-1:0] addr;
        logic [7:0]       upper_wr;
        logic [7:0]       middle_wr;
    } t_line_req;

    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic                  clr;
        logic [BIN_W-1:0]      addr;
        logic [COUNT_BITS-1:0] wr_data;
    } t_hist_req;

    typedef struct packed {
        logic                  start;
        logic [DVD_W-1:0]      dividend;
        logic [COUNT_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    // Window slot of neighbor k, clockwise from the top neighbor.
    function automatic logic [3:0] nbr_slot(input logic [2:0] k);
        logic [3:0] s;
        case (k)
            3'd0:    s = 4'd1;
            3'd1:    s = 4'd2;
            3'd2:    s = 4'd5;
            3'd3:    s = 4'd8;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd6;
            3'd6:    s = 4'd3;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v < SIZE_MIN) begin
            r = SIZE_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/lbp_masked_histogram.sv =====
// Top level: sequencer, 3x3 window and shared compare unit of the LBP histogram.
// After reset the block stalls its input while both line stores are swept to zero;
// configuration writes are taken meanwhile. One item is handled at a time. A pixel
// runs the line store read, eight neighbor compares through one shared comparator,
// and a read-modify-write of the histogram bin; a border or masked pixel skips the
// bin update. A bin read runs the 36-step restoring divider that forms the 1.16
// fraction; a read while the total is zero skips the divider, and a start or an
// unused command goes straight to the finish state.
// A finished result waits in the output register until it is transferred.
module lbp_masked_histogram
    import lbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_lbp_in          i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_lbp_out         o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LRD  = 8'b0000_0010,
        S_CMP  = 8'b0000_0100,
        S_DEC  = 8'b0000_1000,
        S_HWR  = 8'b0001_0000,
        S_BIN  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_width;
    logic [CFG_W-1:0]      r_height;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [7:0]            r_win [9];
    logic [7:0]            r_pix;
    logic [1:0]            r_cmd;
    logic                  r_elig;
    logic [2:0]            r_k;
    logic [7:0]            r_code;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_pvalid;
    logic [COUNT_BITS-1:0] r_count;
    logic [FRAC_W-1:0]     r_frac;
    logic                  r_out_valid;
    t_lbp_out              r_out;

    t_line_req             w_line_req;
    t_hist_req             w_hist_req;
    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;
    logic [7:0]            w_upper;
    logic [7:0]            w_middle;
    logic                  w_line_rdy;
    logic [COUNT_BITS-1:0] w_hist_rd;
    logic                  w_accept;
    logic                  w_clean;
    logic                  w_le;
    logic                  w_out_free;
    logic [CFG_W-1:0]      w_w_eff;
    logic [CFG_W-1:0]      w_h_eff;

    assign o_in_stall = !(r_state == S_IDLE && w_line_rdy);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_w_eff    = clamp_size(r_width, WIDTH_MX);
    assign w_h_eff    = clamp_size(r_height, HEIGHT_MX);

    always_comb begin
        w_clean = 1'b1;
        for (int i = 0; i < 9; i++) begin
            if (r_win[i] == BACKGROUND) begin
                w_clean = 1'b0;
            end
        end
    end

    // The one shared comparator: neighbor k against the centre.
    assign w_le = r_win[nbr_slot(r_k)] <= r_win[4];

    always_comb begin
        w_line_req.rd_en     = w_accept && i_in.cmd == CMD_PIXEL;
        w_line_req.wr_en     = r_state == S_LRD;
        w_line_req.addr      = r_col;
        w_line_req.upper_wr  = w_middle;
        w_line_req.middle_wr = r_pix;

        w_hist_req.rd_en   = (w_accept && i_in.cmd == CMD_READ)
                             || (r_state == S_DEC && r_elig && w_clean);
        w_hist_req.wr_en   = r_state == S_HWR;
        w_hist_req.clr     = w_accept && i_in.cmd == CMD_START;
        w_hist_req.addr    = (r_state == S_IDLE) ? i_in.bin_index : r_code;
        w_hist_req.wr_data = sat_inc(w_hist_rd);

        w_div_req.start    = r_state == S_BIN && r_total != '0;
        w_div_req.dividend = {w_hist_rd, FRAC_SH'(0)};
        w_div_req.divisor  = r_total;
    end

    lbp_line_buf u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_line_req),
        .o_upper  (w_upper),
        .o_middle (w_middle),
        .o_ready  (w_line_rdy)
    );

    lbp_hist_mem u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_hist_req),
        .o_rd_data (w_hist_rd)
    );

    lbp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= 8'd0;
            end
        end else begin
            // A result sent from the finish state refills the register in the same cycle.
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= i_in.cmd;
                        r_pix    <= i_in.pixel_value;
                        r_elig   <= r_row >= ROW_W'(2) && r_col >= COL_W'(2);
                        r_pvalid <= 1'b0;
                        r_code   <= 8'd0;
                        r_count  <= '0;
                        r_frac   <= '0;
                        r_k      <= 3'd0;
                        case (i_in.cmd)
                            CMD_PIXEL: r_state <= S_LRD;
                            CMD_READ:  r_state <= S_BIN;
                            CMD_START: begin
                                r_total <= '0;
                                r_col   <= '0;
                                r_row   <= '0;
                                r_state <= S_FIN;
                            end
                            default:   r_state <= S_FIN;
                        endcase
                    end
                end
                S_LRD: begin
                    for (int r = 0; r < 3; r++) begin
                        r_win[r*3]   <= r_win[r*3+1];
                        r_win[r*3+1] <= r_win[r*3+2];
                    end
                    r_win[2] <= w_upper;
                    r_win[5] <= w_middle;
                    r_win[8] <= r_pix;
                    r_state  <= S_CMP;
                end
                S_CMP: begin
                    r_code[3'd7 - r_k] <= w_le;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_elig && w_clean) begin
                        r_state <= S_HWR;
                    end else begin
                        r_code  <= 8'd0;
                        r_state <= S_FIN;
                    end
                end
                S_HWR: begin
                    r_total  <= sat_inc(r_total);
                    r_pvalid <= 1'b1;
                    r_state  <= S_FIN;
                end
                S_BIN: begin
                    r_count <= w_hist_rd;
                    r_state <= (r_total != '0) ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_frac  <= (w_div_rsp.quotient > DVD_W'(FRAC_ONE))
                                   ? FRAC_ONE : w_div_rsp.quotient[FRAC_W-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.pattern_valid  <= r_pvalid;
                        r_out.pattern_code   <= r_code;
                        r_out.bin_count      <= r_count;
                        r_out.bin_fraction   <= r_frac;
                        r_out.total_patterns <= r_total;
                        if (r_cmd == CMD_PIXEL) begin
                            if ({1'b0, r_col} + CFG_W'(1) >= w_w_eff) begin
                                r_col <= '0;
                                if ({1'b0, r_row} + CFG_W'(1) >= w_h_eff) begin
                                    r_row <= '0;
                                end else begin
                                    r_row <= r_row + ROW_W'(1);
                                end
                            end else begin
                                r_col <= r_col + COL_W'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Input is held off for the whole line store sweep.
    a_stall_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_line_rdy |-> o_in_stall)
        else $error("input taken during line store sweep");

    // The total only falls through a start command.
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_hist_req.clr |=> r_total >= $past(r_total))
        else $error("pattern total decreased without a start");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.bin_fraction <= FRAC_ONE)
        else $error("fraction above one");

    a_pattern_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.pattern_valid |-> o_out.total_patterns != '0)
        else $error("counted pattern with zero total");

    // The divider is only started from the bin state and finishes before a new item.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == S_DIV)
        else $error("divider result outside the divide state");

endmodule

// ===== hdl/lbp_line_buf.sv =====
// Two line stores of gray pixels with a clearing sweep after reset.
module lbp_line_buf
    import lbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_line_req  i_req,
    output logic [7:0] o_upper,
    output logic [7:0] o_middle,
    output logic       o_ready
);

    logic [7:0]       r_upper_mem  [MAX_WIDTH];
    logic [7:0]       r_middle_mem [MAX_WIDTH];
    logic             r_clr_busy;
    logic [COL_W-1:0] r_clr_addr;
    logic [7:0]       r_upper;
    logic [7:0]       r_middle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + COL_W'(1);
            if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_upper_mem[r_clr_addr]  <= 8'd0;
            r_middle_mem[r_clr_addr] <= 8'd0;
        end else if (i_req.wr_en) begin
            r_upper_mem[i_req.addr]  <= i_req.upper_wr;
            r_middle_mem[i_req.addr] <= i_req.middle_wr;
        end
        if (i_req.rd_en) begin
            r_upper  <= r_upper_mem[i_req.addr];
            r_middle <= r_middle_mem[i_req.addr];
        end
    end

    assign o_upper  = r_upper;
    assign o_middle = r_middle;
    assign o_ready  = !r_clr_busy;

endmodule

// ===== hdl/lbp_hist_mem.sv =====
// Histogram bin memory with per-bin valid bits so a start clears it at once.
module lbp_hist_mem
    import lbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_hist_req             i_req,
    output logic [COUNT_BITS-1:0] o_rd_data
);

    logic [COUNT_BITS-1:0] r_mem [NBINS];
    logic [NBINS-1:0]      r_bin_vld;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_bin_vld <= '0;
        end else if (i_req.wr_en) begin
            r_bin_vld[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
            r_rd_vld  <= r_bin_vld[i_req.addr];
        end
    end

    // A bin never written since the last clear reads as zero.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hdl/lbp_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module lbp_divider
    import lbp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DVD_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DVD_W-1:0]      r_q;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [COUNT_BITS:0]   w_rem_sh;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_ge;

    assign w_rem_sh = {r_rem, r_q[DVD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_div};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_cnt <= CNT_W'(DVD_W - 1);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_rem_sh[COUNT_BITS-1:0];
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule
